/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rppa_pkg.sv */
// ---------------------------------------------------------------------------
// Random page pool allocator package
// Payload types, codes and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`default_nettype none

package rppa_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int PAGE_COUNT_W   = 11;
    localparam int ID_W           = 10;
    localparam int TOTAL_W        = 11;
    localparam int RAND_W         = 32;
    localparam int DIV_STEP_W     = $clog2(RAND_W + 1);

    localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RESET = PAGE_COUNT_W'(1024);

    typedef enum logic [1:0] {
        KIND_TAKE    = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_MAP     = 2'd2,
        KIND_UNMAP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ALREADY = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_BAD_ID  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    page_id;
        logic [RAND_W-1:0]  random;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    chosen_page;
        logic [TOTAL_W-1:0] mapped_total;
        status_t            status;
    } out_item_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_CHECK,
        DP_SET_AB,
        DP_MARK,
        DP_RD_B,
        DP_WR1,
        DP_WR2,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  reject;
        logic  mark_reject;
        logic  div_done;
        logic  clear_last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/rppa_div.sv */
// ---------------------------------------------------------------------------
// Restoring remainder unit
// One quotient bit per cycle; remainder of a 32-bit dividend by a divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module rppa_div
    import rppa_pkg::*;
#(
    parameter int DW = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAND_W-1:0] dividend,
    input  wire logic [DW-1:0]     divisor,
    output logic                   done,
    output logic [DW-1:0]          rem
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [RAND_W-1:0]     dvd_reg;
    logic [DW-1:0]         dsr_reg;
    logic [DW-1:0]         rem_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= DIV_STEP_W'(RAND_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - DIV_STEP_W'(1);
            if (step_reg == DIV_STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* rtl/rppa_datapath.sv */
// ---------------------------------------------------------------------------
// Random page pool allocator datapath
// Order and slot memories, mapped count, request and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module rppa_datapath
    import rppa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [PAGE_COUNT_W-1:0] cfg_wr_data,
    input  wire in_item_t                in_item,
    input  wire dp_cmd_t                 cmd,
    output dp_status_t                   st,
    output out_item_t                    out_item
);

    localparam int IDW = $clog2(POOL_DEPTH);
    localparam int CW  = $clog2(POOL_DEPTH + 1);

    logic [IDW-1:0] order_mem [POOL_DEPTH];
    logic [IDW-1:0] slot_mem  [POOL_DEPTH];

    logic [PAGE_COUNT_W-1:0] page_count_reg;
    logic [CW-1:0]           cnt_reg;
    logic [IDW-1:0]          clr_ctr_reg;

    kind_t             kind_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [RAND_W-1:0] rnd_reg;
    logic [IDW-1:0]    a_reg;
    logic [IDW-1:0]    b_reg;
    logic [IDW-1:0]    ida_reg;
    logic [IDW-1:0]    idb_reg;
    status_t           status_reg;
    out_item_t         out_item_reg;

    logic [IDW-1:0] order_rdata;
    logic [IDW-1:0] slot_rdata;
    logic [IDW-1:0] order_raddr;
    logic           order_we;
    logic [IDW-1:0] order_waddr;
    logic [IDW-1:0] order_wdata;
    logic           slot_we;
    logic [IDW-1:0] slot_waddr;
    logic [IDW-1:0] slot_wdata;

    logic [CW-1:0] n;
    logic          is_pick;
    logic          grows;
    status_t       pre_status;
    status_t       mark_status;
    logic          slot_mapped;
    logic          div_start;
    logic [CW-1:0] divisor;
    logic          div_done;
    logic [CW-1:0] rem;

    always_comb
    begin
        n = (32'(page_count_reg) < 32'(POOL_DEPTH)) ? CW'(page_count_reg) : CW'(POOL_DEPTH);
        is_pick = (kind_reg == KIND_TAKE) || (kind_reg == KIND_RELEASE);
        grows   = (kind_reg == KIND_TAKE) || (kind_reg == KIND_MAP);

        unique case (kind_reg)
            KIND_TAKE:    pre_status = (cnt_reg >= n) ? ST_LIMIT : ST_DONE;
            KIND_RELEASE: pre_status = (cnt_reg == '0) ? ST_LIMIT : ST_DONE;
            default:      pre_status = (32'(pid_reg) >= 32'(n)) ? ST_BAD_ID : ST_DONE;
        endcase

        slot_mapped = CW'(slot_rdata) < cnt_reg;
        if (kind_reg == KIND_MAP)
            mark_status = slot_mapped ? ST_ALREADY : ((cnt_reg >= n) ? ST_LIMIT : ST_DONE);
        else
            mark_status = slot_mapped ? ST_DONE : ST_ALREADY;

        div_start = (cmd.op == DP_CHECK) && (pre_status == ST_DONE) && is_pick;
        divisor   = (kind_reg == KIND_TAKE) ? (n - cnt_reg) : cnt_reg;
    end

    rppa_div #(
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rnd_reg),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb
    begin
        order_raddr = (cmd.op == DP_RD_B) ? b_reg : a_reg;
        order_we    = 1'b0;
        order_waddr = a_reg;
        order_wdata = order_rdata;
        slot_we     = 1'b0;
        slot_waddr  = ida_reg;
        slot_wdata  = b_reg;
        unique case (cmd.op)
            DP_CLEAR:
            begin
                order_we    = 1'b1;
                order_waddr = clr_ctr_reg;
                order_wdata = clr_ctr_reg;
                slot_we     = 1'b1;
                slot_waddr  = clr_ctr_reg;
                slot_wdata  = clr_ctr_reg;
            end
            DP_WR1:
            begin
                order_we = 1'b1;
                slot_we  = 1'b1;
            end
            DP_WR2:
            begin
                order_we    = 1'b1;
                order_waddr = b_reg;
                order_wdata = ida_reg;
                slot_we     = 1'b1;
                slot_waddr  = idb_reg;
                slot_wdata  = a_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
            order_mem[order_waddr] <= order_wdata;
        order_rdata <= order_mem[order_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rdata <= slot_mem[IDW'(pid_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= PAGE_COUNT_RESET;
            cnt_reg        <= '0;
            clr_ctr_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                page_count_reg <= cfg_wr_data;
            if (cmd.op == DP_CLEAR)
                clr_ctr_reg <= clr_ctr_reg + IDW'(1);
            if (cmd.op == DP_WR2)
                cnt_reg <= grows ? (cnt_reg + CW'(1)) : (cnt_reg - CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                kind_reg <= in_item.kind;
                pid_reg  <= in_item.page_id;
                rnd_reg  <= in_item.random;
            end
            DP_CHECK:
                status_reg <= pre_status;
            DP_SET_AB:
            begin
                if (kind_reg == KIND_TAKE)
                begin
                    a_reg <= IDW'(cnt_reg + rem);
                    b_reg <= IDW'(cnt_reg);
                end
                else
                begin
                    a_reg <= IDW'(rem);
                    b_reg <= IDW'(cnt_reg - CW'(1));
                end
            end
            DP_MARK:
            begin
                status_reg <= mark_status;
                a_reg      <= slot_rdata;
                b_reg      <= (kind_reg == KIND_MAP) ? IDW'(cnt_reg)
                                                     : IDW'(cnt_reg - CW'(1));
            end
            DP_RD_B:
                ida_reg <= order_rdata;
            DP_WR1:
                idb_reg <= order_rdata;
            DP_OUT:
            begin
                if (is_pick)
                    out_item_reg.chosen_page <= (status_reg == ST_DONE) ? ID_W'(ida_reg)
                                                                        : '0;
                else
                    out_item_reg.chosen_page <= pid_reg;
                out_item_reg.mapped_total <= TOTAL_W'(cnt_reg);
                out_item_reg.status       <= status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st.kind        = kind_reg;
        st.reject      = pre_status != ST_DONE;
        st.mark_reject = mark_status != ST_DONE;
        st.div_done    = div_done;
        st.clear_last  = clr_ctr_reg == IDW'(POOL_DEPTH - 1);
    end

    assign out_item = out_item_reg;

endmodule

`default_nettype wire

/* rtl/rppa_ctrl.sv */
// ---------------------------------------------------------------------------
// Random page pool allocator controller
// Sequences reset sweep, checks, remainder, table swap and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module rppa_ctrl
    import rppa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SLOT,
        S_RD_A,
        S_RD_B,
        S_WR1,
        S_WR2,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = DP_NOP;
        out_free       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (st.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.op = DP_CHECK;
                if (st.reject)
                    state_next = S_OUT;
                else if (st.kind == KIND_TAKE || st.kind == KIND_RELEASE)
                    state_next = S_DIV;
                else
                    state_next = S_SLOT;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.op     = DP_SET_AB;
                    state_next = S_RD_A;
                end
            end
            S_SLOT:
            begin
                cmd.op     = DP_MARK;
                state_next = st.mark_reject ? S_OUT : S_RD_A;
            end
            S_RD_A:
                state_next = S_RD_B;
            S_RD_B:
            begin
                cmd.op     = DP_RD_B;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.op     = DP_WR1;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                cmd.op     = DP_WR2;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op         = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/random_page_pool_allocator.sv */
// ---------------------------------------------------------------------------
// Random page pool allocator
// Takes, releases and marks page ids held as a mapped/free permutation.
// ---------------------------------------------------------------------------
// Requests enter on in_valid/in_ready as one in_item; each gives exactly one
// out_item on out_valid/out_ready. Configuration: cfg_wr_en writes page_count
// from cfg_wr_data; write it only while the block is idle. One request is
// processed at a time. A take or release runs a bit-serial remainder over the
// 32-bit random value and then a swap through the order and slot memories,
// reading both order entries and writing them back with their slots. The
// result goes out as out_valid and in_ready rise in the same cycle. A mark
// skips the remainder; a request rejected on its first check goes straight
// to its result, and a mark that finds its id already in that state or the
// pool full skips the swap. After reset the block sweeps both memories to
// identity, one entry per cycle through all POOL_DEPTH entries, with in_ready
// low; configuration writes are still taken. The result sits in an output
// register: the next item is accepted while it waits, and a stalled receiver
// holds only the following result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module random_page_pool_allocator
    import rppa_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire logic [PAGE_COUNT_W-1:0] cfg_wr_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire in_item_t                in_item,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output out_item_t                    out_item
);

    dp_cmd_t    cmd;
    dp_status_t st;
    logic       total_ok;

    rppa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    rppa_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .cmd         (cmd),
        .st          (st),
        .out_item    (out_item)
    );

    assign total_ok = 32'(out_item.mapped_total) <= 32'(POOL_DEPTH);

    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `ASSERT_SAME(a_load_on_accept, cmd.op == DP_LOAD, in_valid && in_ready, "load without accept")
    `ASSERT_SAME(a_total_bound, out_valid, total_ok, "mapped total too large")

endmodule

`default_nettype wire

/* sim/random_page_pool_allocator_tb.sv */
// ---------------------------------------------------------------------------
// Random page pool allocator testbench
// Drives take, release and mark items through the valid/ready ports while
// page_count steps through small, odd and full pool sizes. A shadow copy of
// the order and slot tables predicts each result, and the results are
// checked field by field in order. Both sides idle at random; one phase
// holds the output off long enough to back the block up.
// ---------------------------------------------------------------------------
module random_page_pool_allocator_tb;
    import rppa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    typedef struct {
        in_item_t    req;
        int unsigned gap;
    } queued_request_t;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [PAGE_COUNT_W-1:0] cfg_wr_data = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    in_item_t                in_item     = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    out_item_t               out_item;

    queued_request_t pending_requests[$];
    queued_request_t head_request;
    out_item_t       pool_responses[$];
    out_item_t       due_response;

    int unsigned pool_order[POOL_DEPTH_DEF];
    int unsigned pool_slot[POOL_DEPTH_DEF];
    int unsigned pool_mapped;
    int unsigned pool_limit;

    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int tx_idle;
    int rx_wait;
    int holds_requested = 0;
    int holds_served;
    int rx_hold_left;
    int cycle_count = 0;
    int mismatch_count = 0;

    random_page_pool_allocator #(
        .POOL_DEPTH(POOL_DEPTH_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
        begin
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    task automatic swap_slots(input int unsigned a, input int unsigned b);
        int unsigned id_a;
        int unsigned id_b;
        id_a = pool_order[a];
        id_b = pool_order[b];
        pool_order[a] = id_b;
        pool_order[b] = id_a;
        pool_slot[id_a] = b;
        pool_slot[id_b] = a;
    endtask

    function automatic int unsigned pool_size();
        return (pool_limit < POOL_DEPTH_DEF) ? pool_limit : POOL_DEPTH_DEF;
    endfunction

    task automatic apply_pool_request(input in_item_t req);
        int unsigned n;
        int unsigned slot;
        out_item_t   resp;
        n = pool_size();
        resp.chosen_page = req.page_id;
        resp.status = ST_DONE;
        case (req.kind)
            KIND_TAKE:
            begin
                if (pool_mapped >= n)
                begin
                    resp.chosen_page = '0;
                    resp.status = ST_LIMIT;
                end
                else
                begin
                    slot = pool_mapped + req.random % (n - pool_mapped);
                    resp.chosen_page = ID_W'(pool_order[slot]);
                    swap_slots(slot, pool_mapped);
                    pool_mapped++;
                end
            end
            KIND_RELEASE:
            begin
                if (pool_mapped == 0)
                begin
                    resp.chosen_page = '0;
                    resp.status = ST_LIMIT;
                end
                else
                begin
                    slot = req.random % pool_mapped;
                    resp.chosen_page = ID_W'(pool_order[slot]);
                    pool_mapped--;
                    swap_slots(slot, pool_mapped);
                end
            end
            default:
            begin
                if (req.page_id >= n)
                begin
                    resp.status = ST_BAD_ID;
                end
                else
                begin
                    slot = pool_slot[req.page_id];
                    if (req.kind == KIND_MAP)
                    begin
                        if (slot < pool_mapped)
                        begin
                            resp.status = ST_ALREADY;
                        end
                        else if (pool_mapped >= n)
                        begin
                            resp.status = ST_LIMIT;
                        end
                        else
                        begin
                            swap_slots(slot, pool_mapped);
                            pool_mapped++;
                        end
                    end
                    else if (slot >= pool_mapped)
                    begin
                        resp.status = ST_ALREADY;
                    end
                    else
                    begin
                        pool_mapped--;
                        swap_slots(slot, pool_mapped);
                    end
                end
            end
        endcase
        resp.mapped_total = TOTAL_W'(pool_mapped);
        pool_responses.push_back(resp);
    endtask

    // Sender: each item waits out its own gap once the port is free.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_idle = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_pool_request(in_item);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 && tx_idle >= pending_requests[0].gap)
                begin
                    head_request = pending_requests.pop_front();
                    in_item <= head_request.req;
                    in_valid <= 1'b1;
                    tx_idle = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    tx_idle++;
                end
            end
        end
    end

    // Receiver: check each item, then draw the wait before the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pool_responses.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item page=%0d total=%0d status=%0d",
                        out_item.chosen_page, out_item.mapped_total, out_item.status));
                end
                else
                begin
                    due_response = pool_responses.pop_front();
                    if (out_item.chosen_page !== due_response.chosen_page)
                    begin
                        report_mismatch($sformatf("chosen_page %0d, want %0d",
                            out_item.chosen_page, due_response.chosen_page));
                    end
                    if (out_item.mapped_total !== due_response.mapped_total)
                    begin
                        report_mismatch($sformatf("mapped_total %0d, want %0d",
                            out_item.mapped_total, due_response.mapped_total));
                    end
                    if (out_item.status !== due_response.status)
                    begin
                        report_mismatch($sformatf("status %0d, want %0d",
                            out_item.status, due_response.status));
                    end
                end
                rx_wait = rx_gaps_on ? $urandom_range(0, 14) : 0;
            end
            if (rx_hold_left > 0)
            begin
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Long output hold-off, started on request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            holds_served <= 0;
            rx_hold_left <= 0;
        end
        else if (holds_served != holds_requested)
        begin
            holds_served <= holds_requested;
            rx_hold_left <= LONG_HOLD;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_page_count(input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= PAGE_COUNT_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_limit = value;
    endtask

    task automatic wait_pool_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || pool_responses.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic queue_request(input kind_t kind, input int unsigned page_id,
                                 input logic [RAND_W-1:0] rnd_value);
        queued_request_t entry;
        entry.req.kind = kind;
        entry.req.page_id = ID_W'(page_id);
        entry.req.random = rnd_value;
        entry.gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
        pending_requests.push_back(entry);
    endtask

    task automatic queue_random_requests(input int count, input int take_pct);
        int unsigned     n;
        int unsigned     pick;
        int unsigned     page_id;
        kind_t           kind;
        logic [RAND_W-1:0] rnd_value;
        for (int i = 0; i < count; i++)
        begin
            while (pending_requests.size() >= 2)
            begin
                @(negedge clk);
            end
            n = pool_size();
            if ($urandom_range(0, 99) < 60)
            begin
                kind = ($urandom_range(0, 99) < take_pct) ? KIND_TAKE : KIND_RELEASE;
            end
            else
            begin
                kind = ($urandom_range(0, 99) < take_pct) ? KIND_MAP : KIND_UNMAP;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40 && pool_mapped > 0)
            begin
                page_id = pool_order[$urandom_range(0, pool_mapped - 1)];
            end
            else if (pick < 85)
            begin
                page_id = $urandom_range(0, n - 1);
            end
            else
            begin
                page_id = $urandom_range(0, POOL_DEPTH_DEF - 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                rnd_value = '0;
            end
            else if (pick < 20)
            begin
                rnd_value = '1;
            end
            else
            begin
                rnd_value = $urandom();
            end
            queue_request(kind, page_id, rnd_value);
        end
    endtask

    initial
    begin
        int unsigned phase_counts[PHASES];
        for (int i = 0; i < POOL_DEPTH_DEF; i++)
        begin
            pool_order[i] = i;
            pool_slot[i] = i;
        end
        pool_mapped = 0;
        pool_limit = 1024;
        phase_counts = '{1024, 1, 2, $urandom_range(3, 64), 1024, 300, 8, 1024};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_page_count(1024);

        queue_request(KIND_RELEASE, 0, '0);
        queue_request(KIND_UNMAP, 0, '0);
        queue_request(KIND_MAP, 1023, '1);
        queue_request(KIND_MAP, 1023, '0);
        queue_request(KIND_MAP, 10'h2AA, 32'h5555_5555);
        queue_request(KIND_TAKE, 10'h155, '0);
        queue_request(KIND_TAKE, 0, '1);
        queue_request(KIND_TAKE, 1023, 32'hAAAA_AAAA);
        queue_request(KIND_RELEASE, 0, 32'h5555_5555);
        queue_request(KIND_UNMAP, 10'h2AA, '0);
        queue_request(KIND_UNMAP, 10'h155, '1);
        queue_request(KIND_MAP, 0, '0);
        queue_request(KIND_RELEASE, 1023, '1);
        queue_request(KIND_UNMAP, 0, '0);
        wait_pool_idle();

        write_page_count(2);
        queue_request(KIND_TAKE, 0, '1);
        queue_request(KIND_MAP, 1023, '0);
        queue_request(KIND_UNMAP, 2, '0);
        wait_pool_idle();

        write_page_count(1);
        queue_request(KIND_MAP, 0, '0);
        repeat (4) queue_request(KIND_RELEASE, 0, $urandom());
        queue_request(KIND_TAKE, 0, '1);
        wait_pool_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_page_count(phase_counts[p]);
            tx_gaps_on = (p != 2 && p != 4);
            rx_gaps_on = (p != 2 && p != 4);
            if (p == 4)
            begin
                holds_requested++;
            end
            queue_random_requests(PHASE_ITEMS, (p == 6) ? 80 : $urandom_range(25, 75));
            wait_pool_idle();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (pool_responses.size() != 0)
        begin
            report_mismatch($sformatf("%0d items never arrived", pool_responses.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
